>>> rtl/core/arctangent_first_quadrant_unit_assert.svh
// Assertion macros for the arctangent unit checker.
// Depends on signals clk and rst_n in the scope of use.
`ifndef ARCTANGENT_FIRST_QUADRANT_UNIT_ASSERT_SVH
`define ARCTANGENT_FIRST_QUADRANT_UNIT_ASSERT_SVH
// same-cycle implication
`define ATFQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define ATFQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

>>> rtl/core/atfq_pkg.sv
// Package for the arctangent unit: Q1.30 constants, coefficients, rounding multiply.
// No dependencies.
package atfq_pkg;
  localparam int INPUT_BITS_DEF      = 16;
  localparam int ANGLE_FRAC_BITS_DEF = 16;
  localparam int QBITS  = 30;
  localparam int UW     = QBITS + 1;
  localparam int TW     = 34;
  localparam int NCOEF  = 9;
  localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;

  typedef logic signed [TW-1:0] term_t;
  typedef logic [UW-1:0]        ufix_t;

  localparam term_t POLY_COEF [NCOEF] = '{
    34'sd3077586, -34'sd17357828, 34'sd46073847, -34'sd80841635,
    34'sd114420763, -34'sd152566896, 34'sd214679118, -34'sd357911922,
    34'sd1073741824
  };

  function automatic term_t q30_mul(term_t t, ufix_t u);
    logic           neg;
    logic [TW-1:0]  m;
    logic [TW+UW:0] prod;
    logic [TW-1:0]  r;
    neg  = t[TW-1];
    m    = neg ? (-t) : t;
    prod = ({1'b0, m} * u) + ((TW+UW+1)'(1) << (QBITS - 1));
    r    = prod[QBITS +: TW];
    return neg ? term_t'(-r) : term_t'(r);
  endfunction
endpackage

>>> rtl/core/arctangent_first_quadrant_unit.sv
// Pipelined first-quadrant arctangent: one beat in, one angle beat out per cycle;
// the stages are an input register, 31 restoring divider steps, a square stage,
// nine Horner multiply stages and an output rounding stage. All stages advance
// together and hold while the output beat is not taken. y is in in_tdata low bits,
// x above it; the angle is unsigned Q1.ANGLE_FRAC_BITS radians. Depends on atfq_pkg.
module arctangent_first_quadrant_unit
  import atfq_pkg::*;
#(
  parameter int INPUT_BITS      = INPUT_BITS_DEF,
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
  localparam int IN_W  = ((2*INPUT_BITS + 7) / 8) * 8,
  localparam int OW    = ANGLE_FRAC_BITS + 1,
  localparam int OUT_W = ((OW + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // y_value, x_value, zero pad
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata   // angle, zero pad
);
  localparam int IW    = INPUT_BITS;
  localparam int NDIV  = UW;
  localparam int NSTG  = NDIV + 1 + NCOEF + 1 + 1;
  localparam int SH    = QBITS - ANGLE_FRAC_BITS;
  localparam logic [31:0] RND = (SH > 0) ? (32'd1 << (SH - 1)) : 32'd0;

  logic en;
  logic [NSTG-1:0] vld_r;

  logic [IW-1:0] y_in, x_in, num, den;
  logic          swap_in;
  logic [IW+QBITS:0] dvd;

  logic [IW-1:0] rem_r  [NDIV];
  logic [UW-1:0] low_r  [NDIV];
  logic [IW-1:0] den_r  [NDIV];
  ufix_t         q_r    [NDIV+1];
  logic          sw_r   [NDIV+1+NCOEF+1];

  ufix_t         u_r    [NCOEF];
  ufix_t         s_r    [NCOEF-1];
  term_t         t_r    [NCOEF+1];
  logic [OW-1:0] ang_r;

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;
  assign y_in      = in_tdata[IW-1:0];
  assign x_in      = in_tdata[2*IW-1:IW];
  assign swap_in   = y_in > x_in;
  assign num       = swap_in ? x_in : y_in;
  assign den       = swap_in ? y_in : ((x_in == '0) ? IW'(1) : x_in);
  assign dvd       = ({{(QBITS+1){1'b0}}, num} << QBITS) + (IW+QBITS+1)'(den >> 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NSTG-2:0], in_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= dvd[IW+QBITS -: IW];
      low_r[0] <= dvd[UW-1:0];
      den_r[0] <= den;
      q_r[0]   <= '0;
      sw_r[0]  <= swap_in;
    end
  end

  for (genvar k = 1; k <= NDIV; k++) begin : g_div
    logic [IW:0] trial, diff;
    logic        ge;
    assign trial = {rem_r[k-1], low_r[k-1][UW-1]};
    assign diff  = trial - {1'b0, den_r[k-1]};
    assign ge    = trial >= {1'b0, den_r[k-1]};
    always_ff @(posedge clk) begin
      if (en) begin
        q_r[k]   <= {q_r[k-1][UW-2:0], ge};
        sw_r[k]  <= sw_r[k-1];
      end
    end
    if (k < NDIV) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= ge ? diff[IW-1:0] : trial[IW-1:0];
          low_r[k] <= {low_r[k-1][UW-2:0], 1'b0};
          den_r[k] <= den_r[k-1];
        end
      end
    end
  end

  logic [2*UW-1:0] sq;
  assign sq = (q_r[NDIV] * q_r[NDIV]) + ((2*UW)'(1) << (QBITS - 1));

  always_ff @(posedge clk) begin
    if (en) begin
      u_r[0]       <= q_r[NDIV];
      s_r[0]       <= sq[QBITS +: UW];
      t_r[0]       <= POLY_COEF[0];
      sw_r[NDIV+1] <= sw_r[NDIV];
    end
  end

  for (genvar i = 1; i < NCOEF; i++) begin : g_horner
    always_ff @(posedge clk) begin
      if (en) begin
        t_r[i]         <= q30_mul(t_r[i-1], s_r[i-1]) + POLY_COEF[i];
        u_r[i]         <= u_r[i-1];
        sw_r[NDIV+1+i] <= sw_r[NDIV+i];
      end
    end
    if (i < NCOEF - 1) begin : g_sq
      always_ff @(posedge clk) begin
        if (en) begin
          s_r[i] <= s_r[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_r[NCOEF]           <= q30_mul(t_r[NCOEF-1], u_r[NCOEF-1]);
      sw_r[NDIV+1+NCOEF]   <= sw_r[NDIV+NCOEF];
    end
  end

  term_t       ang;
  logic [31:0] uv, rnd_sum;
  assign ang     = sw_r[NDIV+1+NCOEF] ? (term_t'(HALF_PI_Q30) - t_r[NCOEF]) : t_r[NCOEF];
  assign uv      = ang[TW-1] ? 32'd0 :
                   ((ang > term_t'(HALF_PI_Q30)) ? HALF_PI_Q30 : ang[31:0]);
  assign rnd_sum = (uv + RND) >> SH;

  always_ff @(posedge clk) begin
    if (en) begin
      ang_r                <= rnd_sum[OW-1:0];
    end
  end

  assign out_tvalid = vld_r[NSTG-1];
  assign out_tdata  = OUT_W'(ang_r);
endmodule

>>> rtl/core/atfq_checker.sv
// Port-level checker for the arctangent unit, bound to the top level.
// Depends on atfq_pkg and arctangent_first_quadrant_unit_assert.svh.
`include "arctangent_first_quadrant_unit_assert.svh"
module atfq_checker
  import atfq_pkg::*;
#(
  parameter int INPUT_BITS      = INPUT_BITS_DEF,
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
  localparam int IN_W  = ((2*INPUT_BITS + 7) / 8) * 8,
  localparam int OW    = ANGLE_FRAC_BITS + 1,
  localparam int OUT_W = ((OW + 7) / 8) * 8
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic [IN_W-1:0]  in_tdata,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);
  localparam int SH = QBITS - ANGLE_FRAC_BITS;
  localparam longint RL = (SH > 0) ?
    ((longint'(HALF_PI_Q30) + (64'sd1 <<< (SH - 1))) >>> SH) : longint'(HALF_PI_Q30);

  logic [63:0] out_ext;
  assign out_ext = 64'(out_tdata);

  `ATFQ_ASSERT_NOW(a_angle_range, out_tvalid, out_ext <= 64'(RL), "angle above pi/2")
  `ATFQ_ASSERT_NOW(a_ready_free, !out_tvalid || out_tready, in_tready, "input held needlessly")
  `ATFQ_ASSERT_NEXT(a_stall_hold, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata), "stalled output beat changed")
  `ATFQ_ASSERT_NOW(a_in_known, in_tvalid && in_tready, !$isunknown(in_tdata),
    "accepted input beat has unknown bits")
endmodule

bind arctangent_first_quadrant_unit atfq_checker #(
  .INPUT_BITS(INPUT_BITS),
  .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
) u_atfq_checker (.*);
